[rtl/dpq_pkg.sv]
// Package for the deduplicating priority request queue.
// Holds shared widths, action and status codes, and the front-to-back command type.
package dpq_pkg;
	localparam int unsigned CapacityDefault = 16;
	localparam int unsigned KeyBitsDefault  = 32;
	localparam int unsigned KeyW   = 32;
	localparam int unsigned PriW   = 32;
	localparam int unsigned FrameW = 64;
	localparam int unsigned BudgetW = 8;
	localparam int unsigned CountW = 5;

	typedef enum logic [1:0] {
		ACT_REQUEST = 2'd0,
		ACT_POP     = 2'd1,
		ACT_CLEAR   = 2'd2,
		ACT_QUERY   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_MERGED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]          action;
		logic [KeyW-1:0]     key;
		logic [PriW-1:0]     pri;
		logic [FrameW-1:0]   frame;
		logic [BudgetW-1:0]  budget;
	} cmd_t;
endpackage

[rtl/dpq_if.sv]
// Valid/ready channel interfaces for the queue's input and result beats.
// Depends on dpq_pkg for field widths.
interface dpq_in_if;
	import dpq_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          action;
	logic [KeyW-1:0]     key;
	logic [PriW-1:0]     priority_req;
	logic [FrameW-1:0]   frame;
	logic [BudgetW-1:0]  budget;
	modport source (output valid, action, key, priority_req, frame, budget, input ready);
	modport sink   (input valid, action, key, priority_req, frame, budget, output ready);
endinterface

interface dpq_out_if;
	import dpq_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic               entry_valid;
	logic [KeyW-1:0]    out_key;
	logic [PriW-1:0]    out_priority;
	logic [FrameW-1:0]  out_frame;
	logic               found;
	logic [CountW-1:0]  pending_count;
	logic               last;
	modport source (output valid, status, entry_valid, out_key, out_priority, out_frame,
		found, pending_count, last, input ready);
	modport sink   (input valid, status, entry_valid, out_key, out_priority, out_frame,
		found, pending_count, last, output ready);
endinterface

[rtl/dpq_front.sv]
// Front end: accepts input beats, masks the key and queues commands for the back end.
// Depends on dpq_pkg and dpq_in_if.
module dpq_front #(
	parameter int unsigned KEY_BITS = dpq_pkg::KeyBitsDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	dpq_in_if.sink          in_ch,
	output dpq_pkg::cmd_t   cmd,
	output logic            cmd_valid,
	input  logic            cmd_ready
);
	import dpq_pkg::*;

	localparam logic [KeyW-1:0] KeyMask = (KEY_BITS >= KeyW) ? '1 :
		KeyW'((64'd1 << KEY_BITS) - 64'd1);

	// Two-entry queue.
	cmd_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop = cmd_valid && cmd_ready;
	assign cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{action: in_ch.action, key: in_ch.key & KeyMask,
				pri: in_ch.priority_req, frame: in_ch.frame, budget: in_ch.budget};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("front queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) (cnt_q == 2'd0) |-> !pop)
		else $error("front queue underflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("front queue count slip");
endmodule

[rtl/dpq_back.sv]
// Back end: entry table, one-entry-per-cycle scans for lookup, best search and compaction.
// Depends on dpq_pkg and dpq_out_if.
module dpq_back #(
	parameter int unsigned CAPACITY = dpq_pkg::CapacityDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dpq_pkg::cmd_t   cmd,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	dpq_out_if.source       out_ch
);
	import dpq_pkg::*;

	localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned NW   = $clog2(CAPACITY + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_FIND  = 6'b000010,
		S_BEST  = 6'b000100,
		S_EMIT  = 6'b001000,
		S_SHIFT = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	logic [KeyW-1:0]   keys_q [CAPACITY];
	logic [PriW-1:0]   pris_q [CAPACITY];
	logic [FrameW-1:0] frms_q [CAPACITY];
	logic [NW-1:0]     occ_q;

	state_t            state_q;
	cmd_t              c_q;
	logic [NW-1:0]     i_q;
	logic [IdxW-1:0]   best_q;
	logic              have_q;
	logic [BudgetW-1:0] left_q;

	logic [1:0]        o_status_q;
	logic              o_ev_q, o_found_q, o_last_q, o_valid_q;
	logic [KeyW-1:0]   o_key_q;
	logic [PriW-1:0]   o_pri_q;
	logic [FrameW-1:0] o_frm_q;
	logic [NW-1:0]     o_cnt_q;

	logic [IdxW-1:0] ii;
	logic            better;
	logic [NW-1:0]   pop_left;
	assign ii = i_q[IdxW-1:0];
	assign better = !have_q || (pris_q[ii] > pris_q[best_q]) ||
		(pris_q[ii] == pris_q[best_q] && frms_q[ii] < frms_q[best_q]);

	// Entries that remain once a pop has taken min(budget, occupancy) of them.
	assign pop_left = ({{BudgetW{1'b0}}, occ_q} > {{NW{1'b0}}, cmd.budget}) ?
		occ_q - NW'(cmd.budget) : '0;

	assign cmd_ready = (state_q == S_IDLE) && !o_valid_q;

	assign out_ch.valid = o_valid_q;
	assign out_ch.status = o_status_q;
	assign out_ch.entry_valid = o_ev_q;
	assign out_ch.out_key = o_key_q;
	assign out_ch.out_priority = o_pri_q;
	assign out_ch.out_frame = o_frm_q;
	assign out_ch.found = o_found_q;
	assign out_ch.pending_count = CountW'(o_cnt_q);
	assign out_ch.last = o_last_q;

	logic out_take;
	assign out_take = o_valid_q && out_ch.ready;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid && cmd_ready) c_q <= cmd;
		if (state_q == S_FIND && i_q < occ_q && keys_q[ii] == c_q.key
			&& c_q.action == ACT_REQUEST) begin
			if (c_q.pri > pris_q[ii]) pris_q[ii] <= c_q.pri;
			if (c_q.frame < frms_q[ii]) frms_q[ii] <= c_q.frame;
		end
		if (state_q == S_FIND && i_q >= occ_q && c_q.action == ACT_REQUEST
			&& occ_q < NW'(CAPACITY)) begin
			keys_q[occ_q[IdxW-1:0]] <= c_q.key;
			pris_q[occ_q[IdxW-1:0]] <= c_q.pri;
			frms_q[occ_q[IdxW-1:0]] <= c_q.frame;
		end
		if (state_q == S_SHIFT && i_q + NW'(1) < occ_q) begin
			keys_q[ii] <= keys_q[IdxW'(i_q + NW'(1))];
			pris_q[ii] <= pris_q[IdxW'(i_q + NW'(1))];
			frms_q[ii] <= frms_q[IdxW'(i_q + NW'(1))];
		end
		if (state_q == S_BEST && i_q < occ_q && better) best_q <= ii;
		if (state_q == S_EMIT) begin
			o_key_q <= keys_q[best_q];
			o_pri_q <= pris_q[best_q];
			o_frm_q <= frms_q[best_q];
		end else if (state_q == S_IDLE) begin
			o_key_q <= '0;
			o_pri_q <= '0;
			o_frm_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q <= '0;
			i_q <= '0;
			have_q <= 1'b0;
			left_q <= '0;
			o_valid_q <= 1'b0;
			o_status_q <= ST_DONE;
			o_ev_q <= 1'b0;
			o_found_q <= 1'b0;
			o_last_q <= 1'b0;
			o_cnt_q <= '0;
		end else begin
			if (out_take) o_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						i_q <= '0;
						o_ev_q <= 1'b0;
						o_found_q <= 1'b0;
						o_status_q <= ST_DONE;
						o_last_q <= 1'b1;
						case (cmd.action)
							ACT_CLEAR: begin
								occ_q <= '0;
								o_cnt_q <= '0;
								o_valid_q <= 1'b1;
							end
							ACT_POP: begin
								if (cmd.budget == '0 || occ_q == '0) begin
									o_cnt_q <= occ_q;
									o_valid_q <= 1'b1;
								end else begin
									// Every popped beat reports the count after the whole pop.
									o_cnt_q <= pop_left;
									left_q <= cmd.budget;
									have_q <= 1'b0;
									state_q <= S_BEST;
								end
							end
							default: begin
								if (cmd.key == '0) begin
									o_status_q <= (cmd.action == ACT_REQUEST) ? ST_EMPTY : ST_DONE;
									o_cnt_q <= occ_q;
									o_valid_q <= 1'b1;
								end else begin
									state_q <= S_FIND;
								end
							end
						endcase
					end
				end
				S_FIND: begin
					if (i_q < occ_q && keys_q[ii] == c_q.key) begin
						o_status_q <= (c_q.action == ACT_REQUEST) ? ST_MERGED : ST_DONE;
						o_found_q <= (c_q.action == ACT_QUERY);
						o_cnt_q <= occ_q;
						o_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (i_q >= occ_q) begin
						if (c_q.action == ACT_REQUEST) begin
							if (occ_q < NW'(CAPACITY)) begin
								occ_q <= occ_q + NW'(1);
								o_cnt_q <= occ_q + NW'(1);
								o_status_q <= ST_DONE;
							end else begin
								o_cnt_q <= occ_q;
								o_status_q <= ST_FULL;
							end
						end else begin
							o_cnt_q <= occ_q;
						end
						o_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + NW'(1);
					end
				end
				S_BEST: begin
					if (i_q < occ_q) begin
						have_q <= 1'b1;
						i_q <= i_q + NW'(1);
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					o_ev_q <= 1'b1;
					i_q <= {1'b0, best_q};
					left_q <= left_q - BudgetW'(1);
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (i_q + NW'(1) < occ_q) begin
						i_q <= i_q + NW'(1);
					end else begin
						occ_q <= occ_q - NW'(1);
						o_last_q <= (left_q == '0) || (occ_q == NW'(1));
						o_valid_q <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_take) begin
						if (o_last_q) begin
							state_q <= S_IDLE;
						end else begin
							i_q <= '0;
							have_q <= 1'b0;
							state_q <= S_BEST;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) occ_q <= NW'(CAPACITY))
		else $error("occupancy beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && !out_ch.ready) |=> o_valid_q && $stable(o_key_q))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && o_ev_q) |-> !o_found_q)
		else $error("popped entry flagged as query answer");
endmodule

[rtl/dedup_priority_request_queue.sv]
// Top level of the deduplicating priority request queue.
// Depends on dpq_pkg, dpq_if, dpq_front and dpq_back.
//
// Usage: input beats arrive on in_ch (action, key, priority_req, frame,
// budget) and result beats leave on out_ch, both valid/ready channels where
// a beat moves when valid and ready are high at a rising edge of clk.
// A request merges into a pending entry of the same key or appends a new one;
// a pop emits up to budget entries, highest priority then earliest frame then
// oldest position; a clear empties the table; a query reports presence.
// Every result carries the pending count after the whole item.
// A request or query scans the table key by key, one entry per cycle, before
// its result beat. Each popped entry takes one scan to find the best entry
// and one to close the gap it leaves; clear and empty-key items need no scan.
// The front end holds two items in a small queue, so input beats are taken
// while the back end works. When the receiver stalls, the result register
// holds its beat and the back end waits; the front queue then fills and
// in_ch.ready falls. Reset (arst_n low) empties the table and both queues.
module dedup_priority_request_queue #(
	parameter int unsigned CAPACITY = dpq_pkg::CapacityDefault,
	parameter int unsigned KEY_BITS = dpq_pkg::KeyBitsDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	dpq_in_if.sink    in_ch,
	dpq_out_if.source out_ch
);
	import dpq_pkg::*;

	cmd_t cmd;
	logic cmd_valid, cmd_ready;

	dpq_front #(.KEY_BITS(KEY_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
	);

	dpq_back #(.CAPACITY(CAPACITY)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready), .out_ch(out_ch)
	);
endmodule

[test/tb_top.sv]
// Self-checking testbench for the deduplicating priority request queue.
// Depends on dpq_pkg, dpq_if and the dedup_priority_request_queue RTL.
// A behavioural table model predicts every result beat, and a monitor compares them in order.
`timescale 1ns / 100ps

module tb_top;
	import dpq_pkg::*;

	localparam int Cap = 16;

	// One predicted result beat, field for field as it leaves the block.
	typedef struct {
		logic [1:0]        status;
		logic              entry_valid;
		logic [KeyW-1:0]   out_key;
		logic [PriW-1:0]   out_priority;
		logic [FrameW-1:0] out_frame;
		logic              found;
		logic [CountW-1:0] pending_count;
		logic              last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dpq_in_if  in_ch ();
	dpq_out_if out_ch ();

	dedup_priority_request_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// The model's own copy of the pending table.
	logic [KeyW-1:0]   tbl_key [Cap];
	logic [PriW-1:0]   tbl_pri [Cap];
	logic [FrameW-1:0] tbl_frame [Cap];
	int                tbl_count;

	result_t expected_q[$];
	int      mismatches;
	int      idle_pct;
	int      hold_off_cycles;

	// Recently used keys, so that random requests often hit pending entries.
	logic [KeyW-1:0] key_pool[$];

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

	// Returns a blank predicted beat; the pending count is filled in at the end of the step.
	function automatic result_t blank_result();
		result_t r;
		r.status = ST_DONE;
		r.entry_valid = 1'b0;
		r.out_key = '0;
		r.out_priority = '0;
		r.out_frame = '0;
		r.found = 1'b0;
		r.pending_count = '0;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic int find_pending(logic [KeyW-1:0] k);
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_key[i] == k)
				return i;
		end
		return -1;
	endfunction

	// Updates the table for one accepted item and queues the beats it should cause.
	task automatic predict_queue_step(action_t act, logic [KeyW-1:0] k, logic [PriW-1:0] p,
			logic [FrameW-1:0] f, logic [BudgetW-1:0] b);
		result_t beats[$];
		result_t r;
		int idx;
		int n;
		int best;
		int w;
		bit taken [Cap];
		r = blank_result();
		case (act)
			ACT_REQUEST: begin
				if (k == '0) begin
					r.status = ST_EMPTY;
				end else begin
					idx = find_pending(k);
					if (idx >= 0) begin
						if (p > tbl_pri[idx])
							tbl_pri[idx] = p;
						if (f < tbl_frame[idx])
							tbl_frame[idx] = f;
						r.status = ST_MERGED;
					end else if (tbl_count >= Cap) begin
						r.status = ST_FULL;
					end else begin
						tbl_key[tbl_count] = k;
						tbl_pri[tbl_count] = p;
						tbl_frame[tbl_count] = f;
						tbl_count++;
					end
				end
				beats = {beats, r};
			end
			ACT_CLEAR: begin
				tbl_count = 0;
				beats = {beats, r};
			end
			ACT_QUERY: begin
				r.found = (k != '0) && (find_pending(k) >= 0);
				beats = {beats, r};
			end
			default: begin
				n = (b < tbl_count) ? b : tbl_count;
				foreach (taken[i])
					taken[i] = 1'b0;
				// Selection is strict, so exact ties resolve to the lowest position.
				for (int j = 0; j < n; j++) begin
					best = -1;
					for (int i = 0; i < tbl_count; i++) begin
						if (taken[i])
							continue;
						if (best < 0 || tbl_pri[i] > tbl_pri[best] ||
								(tbl_pri[i] == tbl_pri[best] && tbl_frame[i] < tbl_frame[best]))
							best = i;
					end
					taken[best] = 1'b1;
					r = blank_result();
					r.entry_valid = 1'b1;
					r.out_key = tbl_key[best];
					r.out_priority = tbl_pri[best];
					r.out_frame = tbl_frame[best];
					r.last = (j == n - 1);
					beats = {beats, r};
				end
				w = 0;
				for (int i = 0; i < tbl_count; i++) begin
					if (!taken[i]) begin
						tbl_key[w] = tbl_key[i];
						tbl_pri[w] = tbl_pri[i];
						tbl_frame[w] = tbl_frame[i];
						w++;
					end
				end
				tbl_count = w;
				if (n == 0)
					beats = {beats, r};
			end
		endcase
		foreach (beats[i]) begin
			beats[i].pending_count = tbl_count[CountW-1:0];
			expected_q = {expected_q, beats[i]};
		end
	endtask

	// Offers one beat, waits for acceptance and predicts its results.
	// Valid stays high after acceptance, so back-to-back beats need no gap;
	// an idle cycle or the drain drops it.
	task automatic send_item(action_t act, logic [KeyW-1:0] k, logic [PriW-1:0] p,
			logic [FrameW-1:0] f, logic [BudgetW-1:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.key <= k;
		in_ch.priority_req <= p;
		in_ch.frame <= f;
		in_ch.budget <= b;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict_queue_step(act, k, p, f, b);
	endtask

	// Waits until every predicted beat has arrived, plus the longest pop latency.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (40 * Cap) @(posedge clk);
	endtask

	function automatic logic [KeyW-1:0] pick_key();
		if (key_pool.size() != 0 && $urandom_range(99) < 70)
			return key_pool[$urandom_range(key_pool.size() - 1)];
		return {$urandom()};
	endfunction

	// Result checker: each accepted beat is compared against the oldest prediction.
	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result beat: key %h count %0d",
						out_ch.out_key, out_ch.pending_count);
			end else begin
				e = expected_q.pop_front();
				if (out_ch.status !== e.status || out_ch.entry_valid !== e.entry_valid ||
						out_ch.out_key !== e.out_key || out_ch.out_priority !== e.out_priority ||
						out_ch.out_frame !== e.out_frame || out_ch.found !== e.found ||
						out_ch.pending_count !== e.pending_count || out_ch.last !== e.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch: expected st %0d ev %0d key %h pri %h frm %h fnd %0d cnt %0d last %0d",
							e.status, e.entry_valid, e.out_key, e.out_priority, e.out_frame,
							e.found, e.pending_count, e.last);
						$display("          got st %0d ev %0d key %h pri %h frm %h fnd %0d cnt %0d last %0d",
							out_ch.status, out_ch.entry_valid, out_ch.out_key, out_ch.out_priority,
							out_ch.out_frame, out_ch.found, out_ch.pending_count, out_ch.last);
					end
				end
			end
		end
	end

	// The receiver stalls at random, or holds off altogether while a count runs down.
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// Extremes of every field and each special case: empty key, merge both ways,
	// full table, exact ties, oversize budget, pop on an empty table, clear, query.
	task automatic test_directed();
		send_item(ACT_POP, '0, '0, '0, 8'd0);
		send_item(ACT_POP, '0, '0, '0, 8'hFF);
		send_item(ACT_REQUEST, '0, 32'h5, 64'h1, 8'd0);
		send_item(ACT_QUERY, '0, '0, '0, 8'd0);
		send_item(ACT_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
		send_item(ACT_REQUEST, 32'hFFFF_FFFF, 32'h1, 64'h0, 8'd0);
		send_item(ACT_REQUEST, 32'h1, 32'h0, 64'h10, 8'd0);
		send_item(ACT_REQUEST, 32'h1, 32'h7, 64'h20, 8'd0);
		send_item(ACT_QUERY, 32'h1, '0, '0, 8'd0);
		send_item(ACT_QUERY, 32'h2, '0, '0, 8'd0);
		// Two exact ties to check that table order decides.
		send_item(ACT_REQUEST, 32'h3, 32'h7, 64'h10, 8'd0);
		send_item(ACT_REQUEST, 32'h4, 32'h7, 64'h10, 8'd0);
		send_item(ACT_POP, '0, '0, '0, 8'd2);
		send_item(ACT_POP, '0, '0, '0, 8'hFF);
		for (int i = 1; i <= Cap + 2; i++)
			send_item(ACT_REQUEST, 32'h100 + i, $urandom_range(3), {$urandom(), $urandom()}, 8'd0);
		send_item(ACT_REQUEST, 32'h101, 32'hFFFF_FFFF, 64'h0, 8'd0);
		send_item(ACT_CLEAR, '0, '0, '0, 8'd0);
		send_item(ACT_QUERY, 32'h101, '0, '0, 8'd0);
		drain();
	endtask

	// Mostly requests on a small key pool with random content, pops with small budgets,
	// occasional clears, queries and full random noise.
	task automatic test_random(int count);
		int sel;
		logic [KeyW-1:0] k;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			k = pick_key();
			if (key_pool.size() < 24 && k != '0)
				key_pool = {key_pool, k};
			if (sel < 55)
				send_item(ACT_REQUEST, ($urandom_range(19) == 0) ? '0 : k,
					($urandom_range(3) == 0) ? $urandom_range(3) : $urandom(),
					($urandom_range(3) == 0) ? {62'd0, 2'($urandom())} : {$urandom(), $urandom()},
					8'($urandom()));
			else if (sel < 75)
				send_item(ACT_POP, k, $urandom(), {$urandom(), $urandom()},
					($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(4)));
			else if (sel < 80)
				send_item(ACT_CLEAR, k, $urandom(), {$urandom(), $urandom()}, 8'($urandom()));
			else
				send_item(ACT_QUERY, ($urandom_range(9) == 0) ? {$urandom()} : k,
					$urandom(), {$urandom(), $urandom()}, 8'($urandom()));
		end
	endtask

	// The receiver holds off while requests and a large pop keep arriving,
	// so the result register and the front queue fill and input ready falls.
	task automatic test_back_pressure();
		@(posedge clk);
		hold_off_cycles <= 600;
		for (int i = 0; i < 6; i++)
			send_item(ACT_REQUEST, 32'h900 + i, $urandom(), {$urandom(), $urandom()}, 8'd0);
		send_item(ACT_POP, '0, '0, '0, 8'hFF);
		send_item(ACT_QUERY, 32'h900, '0, '0, 8'd0);
		drain();
	endtask

	initial begin
		mismatches = 0;
		tbl_count = 0;
		idle_pct = 18;
		hold_off_cycles = 0;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_REQUEST;
		in_ch.key = '0;
		in_ch.priority_req = '0;
		in_ch.frame = '0;
		in_ch.budget = '0;
		out_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(150);
		// A long stretch without any idling on either side.
		idle_pct = 0;
		test_random(80);
		idle_pct = 18;
		test_back_pressure();
		test_random(120);
		drain();

		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

[files.f]
rtl/dpq_pkg.sv
rtl/dpq_if.sv
rtl/dpq_front.sv
rtl/dpq_back.sv
rtl/dedup_priority_request_queue.sv
test/tb_top.sv
